>>> rtl/pwcf_pkg.sv
// Shared types and constants for the pass window center finder.
package pwcf_pkg;

  localparam int LANES   = 32;
  localparam int LANE_W  = 5;
  localparam int GLANES  = 64;
  localparam int GLANE_W = 6;
  localparam int STEP_W  = 6;
  localparam int COUNT_W = 7;
  localparam int TALLY_W = 4;

  localparam logic [STEP_W-1:0]  FINE_LAST = 6'd63;
  localparam logic [TALLY_W-1:0] MAX_ZONES = 4'd8;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  typedef struct packed {
    logic [STEP_W-1:0] start;
    logic [STEP_W-1:0] stop;
  } pwcf_zone_t;

  typedef struct packed {
    logic               chan;
    logic [3:0]         coarse;
    logic [2:0]         bitd;
    logic [GLANE_W-1:0] qlane;
  } pwcf_item_t;

  typedef struct packed {
    logic [TALLY_W-1:0] tally;
    logic [3:0]         coarse;
    logic [2:0]         bitd;
    logic [STEP_W-1:0]  start;
    logic [STEP_W-1:0]  stop;
    logic [COUNT_W-1:0] count;
  } pwcf_word_t;

endpackage

>>> rtl/pwcf_ifs.sv
// Valid/ready channel interfaces for the input and result transactions.
interface pwcf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        channel;
  logic [3:0]  coarse_delay;
  logic [2:0]  bit_delay;
  logic [5:0]  fine_step;
  logic [31:0] pass_mask;
  logic [5:0]  query_lane;

  modport source(output valid, req_type, channel, coarse_delay, bit_delay, fine_step,
                 pass_mask, query_lane, input ready);
  modport sink(input valid, req_type, channel, coarse_delay, bit_delay, fine_step,
               pass_mask, query_lane, output ready);
endinterface

interface pwcf_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] lane;
  logic [3:0] zone_coarse;
  logic [2:0] zone_bit;
  logic [5:0] zone_start;
  logic [5:0] zone_end;
  logic [5:0] zone_center;
  logic       zone_stored;
  logic       became_best;
  logic       best_valid;
  logic       last;

  modport source(output valid, lane, zone_coarse, zone_bit, zone_start, zone_end,
                 zone_center, zone_stored, became_best, best_valid, last, input ready);
  modport sink(input valid, lane, zone_coarse, zone_bit, zone_start, zone_end,
               zone_center, zone_stored, became_best, best_valid, last, output ready);
endinterface

>>> rtl/pwcf_lane.sv
// Per-lane run tracker: follows one lane's passing run and flags a finished zone.
module pwcf_lane import pwcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  logic              clr,
  input  logic [STEP_W-1:0] step,
  input  logic              pass,
  output logic              emit,
  output pwcf_zone_t        zone
);

  logic              open_r, open_nxt, open_eff;
  logic [STEP_W-1:0] start_r, start_nxt, start_eff;

  // A step of zero begins a new sweep, so any open run is dropped.
  assign open_eff  = open_r && (step != '0);
  assign start_eff = open_eff ? start_r : step;

  always_comb begin
    zone.start = start_eff;
    zone.stop  = step;
    emit       = 1'b0;
    open_nxt   = 1'b0;
    start_nxt  = start_r;
    if (pass) begin
      emit      = (step == FINE_LAST);
      open_nxt  = (step != FINE_LAST);
      start_nxt = start_eff;
    end else begin
      emit       = open_eff && (step > start_r);
      zone.start = start_r;
      zone.stop  = step - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      open_r  <= 1'b0;
      start_r <= '0;
    end else if (upd) begin
      open_r  <= open_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

>>> rtl/pwcf_merge.sv
// Merge stage: drains lane zones in order, updates the per-lane best store, serves reads.
module pwcf_merge import pwcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld_zones,
  input  logic              ld_qry,
  input  logic              clr,
  input  pwcf_item_t        item,
  input  logic [LANES-1:0]  emit,
  input  pwcf_zone_t        zones [LANES],
  output logic              take_ok,
  pwcf_out_if.source        out_ch
);

  // Pending zones of the current sample.
  logic [LANES-1:0]   pend_r;
  logic               qry_pend_r;
  pwcf_zone_t         zst_r [LANES];
  pwcf_item_t         item_r;

  logic               s_valid, s_adv, s_last;
  logic [LANE_W-1:0]  sel;
  logic [LANES-1:0]   sel_hot;
  logic [GLANE_W-1:0] s_addr;

  // Update stage.
  logic               r_valid_r, r_qry_r, r_last_r, r_stale_r;
  logic [GLANE_W-1:0] r_addr_r;
  pwcf_zone_t         r_zone_r;
  logic [3:0]         r_coarse_r;
  logic [2:0]         r_bit_r;
  logic               r_done;

  // Best-window store.
  pwcf_word_t         mem [GLANES];
  pwcf_word_t         rd_r, byp_r, word, wr_word;
  logic [GLANES-1:0]  valid_r;
  logic               vld, stored, better, wr_en;
  logic [TALLY_W-1:0] tally;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] csum;

  logic               out_valid_r;
  logic [GLANE_W-1:0] o_lane_r;
  logic [3:0]         o_coarse_r;
  logic [2:0]         o_bit_r;
  logic [STEP_W-1:0]  o_start_r, o_stop_r, o_center_r;
  logic               o_stored_r, o_best_r, o_bvalid_r, o_last_r;

  always_comb begin
    sel = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (pend_r[i]) sel = LANE_W'(i);
    end
  end

  assign sel_hot = LANES'(1) << sel;
  assign s_last  = ((pend_r & ~sel_hot) == '0);
  assign s_valid = (pend_r != '0) || qry_pend_r;
  assign s_addr  = qry_pend_r ? item_r.qlane : {item_r.chan, sel};
  assign r_done  = r_valid_r && (!out_valid_r || out_ch.ready);
  assign s_adv   = s_valid && (!r_valid_r || r_done);
  assign take_ok = !s_valid && (!r_valid_r || r_done);

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      pend_r     <= '0;
      qry_pend_r <= 1'b0;
    end else if (ld_zones) begin
      pend_r <= emit;
    end else if (ld_qry) begin
      qry_pend_r <= 1'b1;
    end else if (s_adv) begin
      if (qry_pend_r) qry_pend_r <= 1'b0;
      else            pend_r     <= pend_r & ~sel_hot;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_zones || ld_qry) item_r <= item;
    if (ld_zones) zst_r <= zones;
  end

  // A zone read in the same cycle as a write to its lane takes the written word.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      r_valid_r <= 1'b0;
    end else if (s_adv) begin
      r_valid_r <= 1'b1;
    end else if (r_done) begin
      r_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv) begin
      r_qry_r    <= qry_pend_r;
      r_last_r   <= qry_pend_r || s_last;
      r_addr_r   <= s_addr;
      r_zone_r   <= zst_r[sel];
      r_coarse_r <= item_r.coarse;
      r_bit_r    <= item_r.bitd;
      r_stale_r  <= wr_en && (r_addr_r == s_addr);
      rd_r       <= mem[s_addr];
    end
    if (wr_en) begin
      mem[r_addr_r] <= wr_word;
      byp_r         <= wr_word;
    end
  end

  assign word  = r_stale_r ? byp_r : rd_r;
  assign vld   = valid_r[r_addr_r];
  assign tally = vld ? word.tally : '0;
  assign count = {1'b0, r_zone_r.stop} - {1'b0, r_zone_r.start} + COUNT_W'(1);
  assign stored = (tally < MAX_ZONES);
  assign better = !vld || (count > word.count);
  assign wr_en  = r_done && !r_qry_r;

  always_comb begin
    wr_word       = word;
    wr_word.tally = tally + TALLY_W'(stored);
    if (better) begin
      wr_word.coarse = r_coarse_r;
      wr_word.bitd   = r_bit_r;
      wr_word.start  = r_zone_r.start;
      wr_word.stop   = r_zone_r.stop;
      wr_word.count  = count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[r_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (r_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    if (r_qry_r) csum = {1'b0, word.start} + {1'b0, word.count[COUNT_W-1:1]};
    else         csum = {1'b0, r_zone_r.start} + {1'b0, count[COUNT_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (r_done) begin
      o_lane_r <= r_addr_r;
      o_last_r <= r_last_r;
      if (r_qry_r) begin
        o_coarse_r <= vld ? word.coarse : '0;
        o_bit_r    <= vld ? word.bitd : '0;
        o_start_r  <= vld ? word.start : '0;
        o_stop_r   <= vld ? word.stop : '0;
        o_center_r <= vld ? csum[STEP_W-1:0] : '0;
        o_stored_r <= 1'b0;
        o_best_r   <= 1'b0;
        o_bvalid_r <= vld;
      end else begin
        o_coarse_r <= r_coarse_r;
        o_bit_r    <= r_bit_r;
        o_start_r  <= r_zone_r.start;
        o_stop_r   <= r_zone_r.stop;
        o_center_r <= csum[STEP_W-1:0];
        o_stored_r <= stored;
        o_best_r   <= better;
        o_bvalid_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.lane        = o_lane_r;
  assign out_ch.zone_coarse = o_coarse_r;
  assign out_ch.zone_bit    = o_bit_r;
  assign out_ch.zone_start  = o_start_r;
  assign out_ch.zone_end    = o_stop_r;
  assign out_ch.zone_center = o_center_r;
  assign out_ch.zone_stored = o_stored_r;
  assign out_ch.became_best = o_best_r;
  assign out_ch.best_valid  = o_bvalid_r;
  assign out_ch.last        = o_last_r;

endmodule

>>> rtl/pass_window_center_finder.sv
// Top level: 32 lane trackers in parallel feeding a merge stage and the best-window store.
// A sample transaction with N zones passes its records through the pending, update and
// output registers, one record per cycle while the result side is ready; a read's single
// record likewise. The next transaction is taken once the merge stage has issued all
// zones of the previous one.
// Synchronous active-low reset clears all runs, zone tallies and best-window valid bits;
// a clear transaction does the same.
module pass_window_center_finder import pwcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pwcf_in_if.sink     in_ch,
  pwcf_out_if.source  out_ch
);

  logic             take_ok, accept;
  logic             ld_zones, ld_qry, clr;
  logic [LANES-1:0] emit;
  pwcf_zone_t       zones [LANES];
  pwcf_item_t       item;

  // Request code 3 is accepted and dropped without effect.
  assign in_ch.ready = take_ok;
  assign accept      = in_ch.valid && take_ok;
  assign ld_zones    = accept && (in_ch.req_type == REQ_SAMPLE);
  assign ld_qry      = accept && (in_ch.req_type == REQ_READ);
  assign clr         = accept && (in_ch.req_type == REQ_CLEAR);

  assign item.chan   = in_ch.channel;
  assign item.coarse = in_ch.coarse_delay;
  assign item.bitd   = in_ch.bit_delay;
  assign item.qlane  = in_ch.query_lane;

  // Every lane judges the sample at once; run state moves only on a sample or a clear.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pwcf_lane u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .upd  (ld_zones),
      .clr  (clr),
      .step (in_ch.fine_step),
      .pass (in_ch.pass_mask[g]),
      .emit (emit[g]),
      .zone (zones[g])
    );
  end

  // The merge stage drains the flagged zones lowest lane first.
  pwcf_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_zones(ld_zones),
    .ld_qry  (ld_qry),
    .clr     (clr),
    .item    (item),
    .emit    (emit),
    .zones   (zones),
    .take_ok (take_ok),
    .out_ch  (out_ch)
  );

endmodule

>>> rtl/pwcf_checker.sv
// Port-level checker for the pass window center finder, with its bind statement.
module pwcf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_start,
  input logic [5:0] out_end,
  input logic [5:0] out_center,
  input logic [3:0] out_coarse,
  input logic       out_stored,
  input logic       out_best,
  input logic       out_bvalid,
  input logic       out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_center))
    else $error("result changed while stalled");

  a_zone_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_bvalid)
    else $error("zone record without a best window");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bvalid |-> out_start == 6'd0 && out_end == 6'd0 &&
      out_center == 6'd0 && out_coarse == 4'd0 && !out_stored && !out_best)
    else $error("empty read carries window data");

  a_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bvalid |-> out_start <= out_center && out_center <= out_end)
    else $error("center outside window");

endmodule

bind pass_window_center_finder pwcf_checker u_pwcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_start (out_ch.zone_start),
  .out_end   (out_ch.zone_end),
  .out_center(out_ch.zone_center),
  .out_coarse(out_ch.zone_coarse),
  .out_stored(out_ch.zone_stored),
  .out_best  (out_ch.became_best),
  .out_bvalid(out_ch.best_valid),
  .out_last  (out_ch.last)
);

>>> tb/sv/pass_window_center_finder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pass window center finder with a zone record scoreboard.
module pass_window_center_finder_test;
  import pwcf_pkg::*;

  // Request code that the block must ignore.
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int ITEM_GOAL = 470;
  localparam int QUIET_FROM = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  // One input transaction as the sender drives it.
  typedef struct packed {
    logic [1:0]  req;
    logic        chan;
    logic [3:0]  coarse;
    logic [2:0]  bitd;
    logic [5:0]  step;
    logic [31:0] mask;
    logic [5:0]  qlane;
  } point_t;

  // One result transaction, in the order of the result channel's fields.
  typedef struct packed {
    logic [5:0] lane;
    logic [3:0] coarse;
    logic [2:0] bitd;
    logic [5:0] start;
    logic [5:0] stop;
    logic [5:0] center;
    logic       stored;
    logic       best;
    logic       best_valid;
    logic       last;
  } zone_rec_t;

  // The scoreboard keeps its own copy of the per-lane run trackers, zone tallies and best
  // windows, and turns every accepted transaction into the zone records it must cause.
  class center_scoreboard;
    logic               run_open[LANES];
    logic [STEP_W-1:0]  run_start[LANES];
    logic [TALLY_W-1:0] tally[GLANES];
    logic               win_valid[GLANES];
    logic [3:0]         win_coarse[GLANES];
    logic [2:0]         win_bitd[GLANES];
    logic [STEP_W-1:0]  win_start[GLANES];
    logic [STEP_W-1:0]  win_stop[GLANES];
    logic [COUNT_W-1:0] win_count[GLANES];
    logic [STEP_W-1:0]  win_center[GLANES];
    zone_rec_t          awaited[$];
    int                 mismatches;

    function new();
      mismatches = 0;
      clear_stores();
    endfunction

    function void clear_stores();
      for (int i = 0; i < LANES; i++) begin
        run_open[i] = 1'b0;
        run_start[i] = '0;
      end
      for (int g = 0; g < GLANES; g++) begin
        tally[g] = '0;
        win_valid[g] = 1'b0;
        win_coarse[g] = '0;
        win_bitd[g] = '0;
        win_start[g] = '0;
        win_stop[g] = '0;
        win_count[g] = '0;
        win_center[g] = '0;
      end
    endfunction

    // Closes a run into a zone record, updating the quota and the best window.
    function zone_rec_t close_zone(int g, logic [3:0] coarse, logic [2:0] bitd,
                                   logic [STEP_W-1:0] start, logic [STEP_W-1:0] stop);
      zone_rec_t r;
      logic [COUNT_W-1:0] count;
      count = COUNT_W'(stop) - COUNT_W'(start) + COUNT_W'(1);
      r = '0;
      r.lane = GLANE_W'(g);
      r.coarse = coarse;
      r.bitd = bitd;
      r.start = start;
      r.stop = stop;
      r.center = start + STEP_W'(count / 2);
      r.best_valid = 1'b1;
      if (tally[g] < MAX_ZONES) begin
        tally[g] = tally[g] + TALLY_W'(1);
        r.stored = 1'b1;
      end
      // Only a strictly longer zone displaces the current best window.
      if (!win_valid[g] || count > win_count[g]) begin
        win_valid[g] = 1'b1;
        win_coarse[g] = coarse;
        win_bitd[g] = bitd;
        win_start[g] = start;
        win_stop[g] = stop;
        win_count[g] = count;
        win_center[g] = r.center;
        r.best = 1'b1;
      end
      return r;
    endfunction

    function void note_request(point_t p);
      zone_rec_t found[$];
      zone_rec_t r;
      int g;
      case (p.req)
        REQ_CLEAR: clear_stores();
        REQ_READ: begin
          r = '0;
          r.lane = p.qlane;
          if (win_valid[p.qlane]) begin
            r.coarse = win_coarse[p.qlane];
            r.bitd = win_bitd[p.qlane];
            r.start = win_start[p.qlane];
            r.stop = win_stop[p.qlane];
            r.center = win_center[p.qlane];
            r.best_valid = 1'b1;
          end
          r.last = 1'b1;
          awaited.push_back(r);
        end
        REQ_SAMPLE: begin
          // Step zero starts a fresh sweep: open runs are dropped without a record.
          if (p.step == '0) begin
            for (int i = 0; i < LANES; i++) run_open[i] = 1'b0;
          end
          for (int i = 0; i < LANES; i++) begin
            g = p.chan * LANES + i;
            if (p.mask[i]) begin
              if (!run_open[i]) begin
                run_open[i] = 1'b1;
                run_start[i] = p.step;
              end
              if (p.step == FINE_LAST) begin
                found.push_back(close_zone(g, p.coarse, p.bitd, run_start[i], p.step));
                run_open[i] = 1'b0;
              end
            end else if (run_open[i]) begin
              // A fail at or below the run's start closes it silently.
              if (p.step > run_start[i])
                found.push_back(close_zone(g, p.coarse, p.bitd, run_start[i],
                                           p.step - STEP_W'(1)));
              run_open[i] = 1'b0;
            end
          end
          if (found.size() > 0) found[found.size()-1].last = 1'b1;
          foreach (found[k]) awaited.push_back(found[k]);
        end
        default: ;
      endcase
    endfunction

    function void check_record(zone_rec_t got);
      zone_rec_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected zone record for lane %0d start %0d end %0d",
                   got.lane, got.start, got.stop);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: record mismatch");
          $display("  expected lane %0d crs %0d bit %0d st %0d end %0d ctr %0d sto %0b bst %0b vld %0b last %0b",
                   want.lane, want.coarse, want.bitd, want.start, want.stop, want.center,
                   want.stored, want.best, want.best_valid, want.last);
          $display("  actual   lane %0d crs %0d bit %0d st %0d end %0d ctr %0d sto %0b bst %0b vld %0b last %0b",
                   got.lane, got.coarse, got.bitd, got.start, got.stop, got.center,
                   got.stored, got.best, got.best_valid, got.last);
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  pwcf_in_if  in_ch();
  pwcf_out_if out_ch();

  pass_window_center_finder u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  center_scoreboard sb = new();
  int  cycles = 0;
  int  items_sent = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  bit  drained = 1'b0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // The watchdog ends a run that exceeds the cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls in short bursts, one long hold-off on request, and a
  // steady ready once the run reaches its quiet tail.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
        if (out_ch.valid && out_ch.ready)
          sb.check_record({out_ch.lane, out_ch.zone_coarse, out_ch.zone_bit,
                           out_ch.zone_start, out_ch.zone_end, out_ch.zone_center,
                           out_ch.zone_stored, out_ch.became_best, out_ch.best_valid,
                           out_ch.last});
      end
    end
  end

  // Offers one transaction and returns once the block has taken it. Valid stays high but for
  // the occasional gap, so a following transaction can go out back to back.
  task automatic offer(point_t p);
    in_ch.valid <= 1'b1;
    in_ch.req_type <= p.req;
    in_ch.channel <= p.chan;
    in_ch.coarse_delay <= p.coarse;
    in_ch.bit_delay <= p.bitd;
    in_ch.fine_step <= p.step;
    in_ch.pass_mask <= p.mask;
    in_ch.query_lane <= p.qlane;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(p);
    if (p.req != REQ_SPARE) items_sent++;
    if (items_sent >= QUIET_FROM) quiet = 1'b1;
    // Occasional gap on the input side.
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic sample(logic chan, logic [3:0] coarse, logic [2:0] bitd,
                        logic [5:0] step, logic [31:0] mask);
    point_t p;
    p = {REQ_SAMPLE, chan, coarse, bitd, step, mask, 6'($urandom)};
    offer(p);
  endtask

  task automatic read_best(logic [5:0] lane);
    point_t p;
    p = $bits(point_t)'($urandom);
    p.mask = $urandom;
    p.req = REQ_READ;
    p.qlane = lane;
    offer(p);
  endtask

  task automatic plain_request(logic [1:0] req);
    point_t p;
    p = $bits(point_t)'({$urandom, $urandom});
    p.req = req;
    offer(p);
  endtask

  // One fine-step sweep of a random delay point. The mask drifts with sparse flips so
  // that lanes see runs of many lengths; now and then a step goes backward.
  task automatic sweep();
    logic        chan;
    logic [3:0]  coarse;
    logic [2:0]  bitd;
    logic [31:0] mask;
    int          step;
    chan = 1'($urandom);
    coarse = 4'($urandom);
    bitd = 3'($urandom);
    mask = $urandom;
    step = 0;
    while (step <= 63 && items_sent < ITEM_GOAL) begin
      sample(chan, coarse, bitd, 6'(step), mask);
      case ($urandom_range(0, 9))
        0: mask = $urandom;
        1: mask = 32'hFFFF_FFFF;
        2: mask = '0;
        default: mask = mask ^ ($urandom & $urandom & $urandom);
      endcase
      if ($urandom_range(0, 19) == 0)
        step = step - $urandom_range(0, 6);
      else if ($urandom_range(0, 14) == 0)
        step = 63;
      else
        step = step + $urandom_range(1, 3);
      if (step < 0) step = 0;
      if ($urandom_range(0, 11) == 0) read_best(6'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_CLEAR;
    in_ch.channel = 1'b0;
    in_ch.coarse_delay = '0;
    in_ch.bit_delay = '0;
    in_ch.fine_step = '0;
    in_ch.pass_mask = '0;
    in_ch.query_lane = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Reads of empty lanes at both ends, then a full pass at step zero
    // that closes at step one for every lane of channel 0.
    read_best(6'd0);
    read_best(6'd63);
    sample(1'b0, 4'd15, 3'd7, 6'd0, 32'hFFFF_FFFF);
    sample(1'b0, 4'd15, 3'd7, 6'd1, 32'h0000_0000);
    // A run opened at step 10 on lane 0 and failing at step 5 is dropped silently;
    // the same happens for a fail at the very step where the run began.
    sample(1'b0, 4'd0, 3'd0, 6'd10, 32'h0000_0001);
    sample(1'b0, 4'd0, 3'd0, 6'd5, 32'h0000_0000);
    sample(1'b1, 4'd3, 3'd2, 6'd12, 32'h8000_0001);
    sample(1'b1, 4'd3, 3'd2, 6'd12, 32'h0000_0000);
    // A run still open at the last step closes there.
    sample(1'b1, 4'd9, 3'd4, 6'd40, 32'hAAAA_5555);
    sample(1'b1, 4'd9, 3'd4, 6'd63, 32'hFFFF_FFFF);
    // Step zero closes the open runs without a record.
    sample(1'b0, 4'd1, 3'd1, 6'd30, 32'h0F0F_F0F0);
    sample(1'b0, 4'd1, 3'd1, 6'd0, 32'h0000_0000);
    read_best(6'd32);
    read_best(6'd63);
    read_best(6'd0);
    plain_request(REQ_SPARE);
    plain_request(REQ_CLEAR);
    read_best(6'd32);

    // The result side now holds off while the sender keeps offering, so the block
    // fills up and stalls its input.
    hold_req = 1'b1;
    sample(1'b0, 4'd5, 3'd5, 6'd0, 32'hFFFF_FFFF);
    sample(1'b0, 4'd5, 3'd5, 6'd2, 32'h0000_0000);
    sample(1'b0, 4'd5, 3'd5, 6'd3, 32'hFFFF_FFFF);
    sample(1'b0, 4'd5, 3'd5, 6'd63, 32'h0000_0000);

    while (items_sent < ITEM_GOAL) begin
      sweep();
      case ($urandom_range(0, 9))
        0: plain_request(REQ_CLEAR);
        1: plain_request(REQ_SPARE);
        default: ;
      endcase
      // Once in the middle of the run the sender waits for the block to drain.
      if (!drained && items_sent > 200 && !hold_req) begin
        drained = 1'b1;
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
